@@ rtl/core/zeff_pkg.sv @@
`timescale 1ns / 1ps
package zeff_pkg;

	localparam int MASS_W  = 31;
	localparam int SUM_W   = 32;
	localparam int WIDE_W  = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT_MASS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd4;

	localparam logic [WIDE_W-1:0] ROOT_TOP_BIT = 64'd1 << 62;

	typedef struct packed {
		logic [WIDE_W-1:0] x;
		logic [WIDE_W-1:0] r;
	} root_t;

	typedef enum logic [4:0] {
		CS_IDLE  = 5'b00001,
		CS_PROD  = 5'b00010,
		CS_ROOTG = 5'b00100,
		CS_SCALE = 5'b01000,
		CS_ROOTR = 5'b10000
	} cfg_state_t;

	// one digit of the bitwise integer square root
	function automatic root_t root_step(input logic [WIDE_W-1:0] x,
			input logic [WIDE_W-1:0] r, input logic [WIDE_W-1:0] b);
		root_t o;
		logic [WIDE_W:0] t;
		t = {1'b0, r} + {1'b0, b};
		if ({1'b0, x} >= t) begin
			o.x = x - t[WIDE_W-1:0];
			o.r = (r >> 1) + b;
		end else begin
			o.x = x;
			o.r = r >> 1;
		end
		return o;
	endfunction

endpackage

@@ rtl/core/z_expansion_form_factor.sv @@
`timescale 1ns / 1ps
// channel | beat handshake        | payload
// req     | req_valid / req_stall | momentum_sq
// rsp     | rsp_valid / rsp_stall | form_factor, z_difference, out_of_range
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat per cycle while req_stall is low; the path from req beat to rsp beat is:
// entry compare, 32 root digit stages, one multiply stage, 3 + FRACTION_BITS divide
// stages, three product and sum stages, then the output register
// a mass write starts a derived-constant pass (two 32-digit roots
// in a shared unit); req_stall is held high during it
// arst_n clears valid bits, configuration registers and derived constants
// a held rsp beat freezes the whole pipeline; nothing is dropped or repeated
module z_expansion_form_factor import zeff_pkg::*; #(
	parameter int DATA_WIDTH    = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [MASS_W-1:0]      momentum_sq,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic signed [DATA_WIDTH-1:0] form_factor,
	output logic signed [DATA_WIDTH-1:0] z_difference,
	output logic                   out_of_range,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [(DATA_WIDTH > 32 ? DATA_WIDTH : 32)-1:0] cfg_data
);

	localparam int DW   = DATA_WIDTH;
	localparam int FB   = FRACTION_BITS;
	localparam int QSW  = MASS_W + FB;               // qsq at double fraction
	localparam int CMW  = (QSW > WIDE_W ? QSW : WIDE_W) + 1;
	localparam int NRT  = 32;                        // root digits
	localparam int NUMW = 65;
	localparam int DENW = 66;
	localparam int REMW = 68;
	localparam int QB   = FB + 2;                    // quotient bits
	localparam int NDV  = 3 + FB;                    // divide stages
	localparam int P1W  = DW + QB;
	localparam int PQW  = 2 * QB;
	localparam int DZW  = PQW - FB;
	localparam int P2W  = DW + DZW;
	localparam int T2W  = P2W - FB;
	localparam int AW   = (T2W > DW ? T2W : DW) + 3;
	localparam int ZW   = (QB > DW ? QB : DW) + 1;

	// configuration registers
	logic [MASS_W-1:0]  final_mass_q, parent_mass_q;
	logic [DW-1:0]      coef_zero_q, coef_one_q, coef_two_q;

	// derived constants and shared root unit
	cfg_state_t         cs_q;
	logic [SUM_W-1:0]   s_q;
	logic [WIDE_W-1:0]  tp_q;
	logic [SUM_W-1:0]   r0_q;
	logic [WIDE_W-1:0]  cx_q, cr_q, cb_q;
	root_t              cstep;
	logic               busy;
	logic [SUM_W-1:0]   msum;

	logic pipe_en, take, cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = (cs_q != CS_IDLE);
	assign pipe_en   = !(rsp_valid && rsp_stall);
	assign req_stall = busy || !pipe_en;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_mass_q  <= '0;
			parent_mass_q <= '0;
			coef_zero_q   <= '0;
			coef_one_q    <= '0;
			coef_two_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FINAL_MASS:  final_mass_q  <= cfg_data[MASS_W-1:0];
				REG_PARENT_MASS: parent_mass_q <= cfg_data[MASS_W-1:0];
				REG_COEF_ZERO:   coef_zero_q   <= cfg_data[DW-1:0];
				REG_COEF_ONE:    coef_one_q    <= cfg_data[DW-1:0];
				REG_COEF_TWO:    coef_two_q    <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	assign msum  = {1'b0, parent_mass_q} + {1'b0, final_mass_q};
	assign cstep = root_step(cx_q, cr_q, cb_q);

	// s = mB+m, tp = s^2, g = sqrt(mB*m), r0 = sqrt(2*s*g)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_IDLE;
			s_q  <= '0;
			tp_q <= '0;
			r0_q <= '0;
			cx_q <= '0;
			cr_q <= '0;
			cb_q <= '0;
		end else if (cfg_wr && (cfg_index == REG_FINAL_MASS
				|| cfg_index == REG_PARENT_MASS)) begin
			cs_q <= CS_PROD;
		end else begin
			case (cs_q)
				CS_PROD: begin
					s_q  <= msum;
					tp_q <= msum * msum;
					cx_q <= WIDE_W'(parent_mass_q) * WIDE_W'(final_mass_q);
					cr_q <= '0;
					cb_q <= ROOT_TOP_BIT;
					cs_q <= CS_ROOTG;
				end
				CS_ROOTG: begin
					cx_q <= cstep.x;
					cr_q <= cstep.r;
					cb_q <= cb_q >> 2;
					if (cb_q == WIDE_W'(1)) cs_q <= CS_SCALE;
				end
				CS_SCALE: begin
					cx_q <= (WIDE_W'(s_q) * WIDE_W'(cr_q[MASS_W-1:0])) << 1;
					cr_q <= '0;
					cb_q <= ROOT_TOP_BIT;
					cs_q <= CS_ROOTR;
				end
				CS_ROOTR: begin
					cx_q <= cstep.x;
					cr_q <= cstep.r;
					cb_q <= cb_q >> 2;
					if (cb_q == WIDE_W'(1)) begin
						r0_q <= cstep.r[SUM_W-1:0];
						cs_q <= CS_IDLE;
					end
				end
				default: cs_q <= CS_IDLE;
			endcase
		end
	end

	// entry: range check and tp - qsq at double fraction
	logic [CMW-1:0] qs_ext;
	assign qs_ext = CMW'({momentum_sq, {FB{1'b0}}});

	logic              rt_v_s [0:NRT];
	logic              rt_o_s [0:NRT];
	logic [WIDE_W-1:0] rt_x_s [0:NRT];
	logic [WIDE_W-1:0] rt_r_s [0:NRT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s[0] <= 1'b0;
		else if (pipe_en) rt_v_s[0] <= take;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rt_o_s[0] <= qs_ext > CMW'(tp_q);
			rt_x_s[0] <= tp_q - qs_ext[WIDE_W-1:0];
			rt_r_s[0] <= '0;
		end
	end

	// square root of tp - qsq, one digit per stage
	for (genvar k = 0; k < NRT; k++) begin : g_root
		localparam logic [WIDE_W-1:0] BITV = WIDE_W'(1) << (62 - 2 * k);
		root_t st;
		assign st = root_step(rt_x_s[k], rt_r_s[k], BITV);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k+1] <= 1'b0;
			else if (pipe_en) rt_v_s[k+1] <= rt_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rt_o_s[k+1] <= rt_o_s[k];
				rt_x_s[k+1] <= st.x;
				rt_r_s[k+1] <= st.r;
			end
		end
	end

	// dz magnitude = 2*r0*(s-rq) / ((rq+r0)*(s+r0))
	logic [SUM_W-1:0] rq;
	logic [SUM_W:0]   den_a, den_b;
	assign rq    = rt_r_s[NRT][SUM_W-1:0];
	assign den_a = {1'b0, rq} + {1'b0, r0_q};
	assign den_b = {1'b0, s_q} + {1'b0, r0_q};

	logic              dv_v_s   [0:NDV];
	logic              dv_o_s   [0:NDV];
	logic              dv_z_s   [0:NDV];
	logic [REMW-1:0]   dv_rem_s [0:NDV];
	logic [DENW-1:0]   dv_den_s [0:NDV];
	logic [QB-1:0]     dv_q_s   [0:NDV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (pipe_en) dv_v_s[0] <= rt_v_s[NRT];
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dv_o_s[0]   <= rt_o_s[NRT];
			dv_rem_s[0] <= REMW'(NUMW'({r0_q, 1'b0}) * NUMW'(s_q - rq));
			dv_den_s[0] <= DENW'(den_a) * DENW'(den_b);
			dv_z_s[0]   <= (den_a == '0) || (den_b == '0);
			dv_q_s[0]   <= '0;
		end
	end

	// restoring divide: three whole-part steps, then one fraction bit per stage
	for (genvar j = 0; j < NDV; j++) begin : g_div
		logic [REMW-1:0] rin;
		logic [QB-1:0]   qin;
		logic            ge;
		if (j < 3) begin : g_int
			assign rin = dv_rem_s[j];
			assign qin = dv_q_s[j];
		end else begin : g_frac
			assign rin = dv_rem_s[j] << 1;
			assign qin = dv_q_s[j] << 1;
		end
		assign ge = !dv_z_s[j] && (rin >= REMW'(dv_den_s[j]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (pipe_en) dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				dv_o_s[j+1]   <= dv_o_s[j];
				dv_z_s[j+1]   <= dv_z_s[j];
				dv_den_s[j+1] <= dv_den_s[j];
				dv_rem_s[j+1] <= ge ? rin - REMW'(dv_den_s[j]) : rin;
				dv_q_s[j+1]   <= ge ? qin + QB'(1) : qin;
			end
		end
	end

	// a0 + a1*dz + a2*dz^2 with dz = -q
	logic [DW-1:0] mag1, mag2;
	assign mag1 = coef_one_q[DW-1] ? -coef_one_q : coef_one_q;
	assign mag2 = coef_two_q[DW-1] ? -coef_two_q : coef_two_q;

	logic           ar_v_s1, ar_v_s2, ar_v_s3;
	logic           ar_o_s1, ar_o_s2, ar_o_s3;
	logic [QB-1:0]  ar_q_s1, ar_q_s2, ar_q_s3;
	logic [P1W-1:0] ar_p1_s1;
	logic [PQW-1:0] ar_pq_s1;
	logic [P2W-1:0] ar_p2_s2;
	logic signed [AW-1:0] ar_acc_s2, ar_acc_s3;

	logic signed [AW-1:0] a0_ext, t1_ext, t2_ext;
	logic [DZW-1:0] dz2;
	assign a0_ext = AW'($signed(coef_zero_q));
	assign t1_ext = $signed(AW'(ar_p1_s1[P1W-1:FB]));
	assign t2_ext = $signed(AW'(ar_p2_s2[P2W-1:FB]));
	assign dz2    = ar_pq_s1[PQW-1:FB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ar_v_s1 <= 1'b0;
			ar_v_s2 <= 1'b0;
			ar_v_s3 <= 1'b0;
		end else if (pipe_en) begin
			ar_v_s1 <= dv_v_s[NDV];
			ar_v_s2 <= ar_v_s1;
			ar_v_s3 <= ar_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ar_o_s1   <= dv_o_s[NDV];
			ar_q_s1   <= dv_q_s[NDV];
			ar_p1_s1  <= P1W'(mag1) * P1W'(dv_q_s[NDV]);
			ar_pq_s1  <= PQW'(dv_q_s[NDV]) * PQW'(dv_q_s[NDV]);
			ar_o_s2   <= ar_o_s1;
			ar_q_s2   <= ar_q_s1;
			ar_p2_s2  <= P2W'(mag2) * P2W'(dz2);
			ar_acc_s2 <= coef_one_q[DW-1] ? a0_ext + t1_ext : a0_ext - t1_ext;
			ar_o_s3   <= ar_o_s2;
			ar_q_s3   <= ar_q_s2;
			ar_acc_s3 <= coef_two_q[DW-1] ? ar_acc_s2 - t2_ext : ar_acc_s2 + t2_ext;
		end
	end

	// saturation into the output register
	localparam logic signed [AW-1:0] SAT_HI = AW'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
	localparam logic [ZW-1:0] ZLIM = ZW'(1) << (DW - 1);

	logic [DW-1:0] ff_sat, zd_sat;
	logic [ZW-1:0] qz, qneg;
	assign qz   = ZW'(ar_q_s3);
	assign qneg = -qz;

	always_comb begin
		if (ar_acc_s3 > SAT_HI)      ff_sat = SAT_HI[DW-1:0];
		else if (ar_acc_s3 < SAT_LO) ff_sat = SAT_LO[DW-1:0];
		else                         ff_sat = ar_acc_s3[DW-1:0];
		if (qz > ZLIM) zd_sat = ZLIM[DW-1:0];
		else           zd_sat = qneg[DW-1:0];
	end

	logic          rsp_v_q;
	logic [DW-1:0] ff_q, zd_q;
	logic          oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_v_q <= 1'b0;
		else if (pipe_en) rsp_v_q <= ar_v_s3;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			oor_q <= ar_o_s3;
			ff_q  <= ar_o_s3 ? '0 : ff_sat;
			zd_q  <= ar_o_s3 ? '0 : zd_sat;
		end
	end

	assign rsp_valid    = rsp_v_q;
	assign form_factor  = ff_q;
	assign z_difference = zd_q;
	assign out_of_range = oor_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top import zeff_pkg::*; ;

	localparam int DW   = 32;
	localparam int FB   = 24;
	localparam int LAT  = 40 + FB;
	localparam int WDOG = 3000;

	typedef struct packed {
		logic signed [DW-1:0] ff;
		logic signed [DW-1:0] dz;
		logic                 oor;
	} ff_beat_t;

	// directed row: either an absolute qsq or an offset from the in-range edge
	typedef struct {
		bit               edge_rel;
		longint           qv;
		bit               typed;
		ff_beat_t         res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [MASS_W-1:0] momentum_sq = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [DW-1:0] form_factor;
	logic signed [DW-1:0] z_difference;
	logic out_of_range;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// shadow copy of the configuration
	logic [MASS_W-1:0] m_final, m_parent;
	logic signed [DW-1:0] a0, a1, a2;

	ff_beat_t ff_expect_q[$];
	int  n_fail = 0;
	int  n_beats = 0;
	int  n_oor = 0;
	int  idle_cnt = 0;
	bit  quiet = 1'b0;

	always #10 clk = ~clk;

	z_expansion_form_factor #(.DATA_WIDTH(DW), .FRACTION_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .momentum_sq(momentum_sq),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.form_factor(form_factor), .z_difference(z_difference),
		.out_of_range(out_of_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// floor of the integer square root, digit by digit
	function automatic logic [63:0] int_root(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// tp = (mB+m)^2 at 2*FB fraction bits
	function automatic logic [63:0] top_bound();
		logic [63:0] s;
		s = 64'(m_final) + 64'(m_parent);
		return s * s;
	endfunction

	function automatic logic [63:0] coef_mag(input logic signed [DW-1:0] c);
		logic signed [63:0] w;
		w = c;
		return w[63] ? 64'(-w) : 64'(w);
	endfunction

	function automatic ff_beat_t eval_form_factor(input logic [MASS_W-1:0] qsq);
		ff_beat_t o;
		logic [63:0] s, tp, g, r0, rq, qs, q, dz2;
		logic [127:0] num, den, t;
		logic signed [127:0] acc;
		s   = 64'(m_final) + 64'(m_parent);
		tp  = s * s;
		g   = int_root(64'(m_parent) * 64'(m_final));
		r0  = int_root(2 * s * g);
		qs  = 64'(qsq) << FB;
		o   = '0;
		if (qs > tp) begin
			o.oor = 1'b1;
			return o;
		end
		rq  = int_root(tp - qs);
		num = 128'(2 * r0) * 128'(s - rq);
		den = 128'(rq + r0) * 128'(s + r0);
		q   = 0;
		if (den != 0) begin
			for (int i = 0; i < 3 && num >= den; i++) begin
				num = num - den;
				q++;
			end
			for (int i = 0; i < FB; i++) begin
				num = num << 1;
				q = q << 1;
				if (num >= den) begin
					num = num - den;
					q[0] = 1'b1;
				end
			end
		end
		// dz is -q; products are truncated magnitudes
		acc = a0;
		t = (128'(coef_mag(a1)) * 128'(q)) >> FB;
		if (a1 < 0) acc = acc + $signed(t);
		else acc = acc - $signed(t);
		t = (128'(q) * 128'(q)) >> FB;
		dz2 = t[63:0];
		t = (128'(coef_mag(a2)) * 128'(dz2)) >> FB;
		if (a2 < 0) acc = acc - $signed(t);
		else acc = acc + $signed(t);
		if (acc < -(128'sd1 <<< (DW - 1))) o.ff = {1'b1, {(DW-1){1'b0}}};
		else if (acc > ((128'sd1 <<< (DW - 1)) - 1)) o.ff = {1'b0, {(DW-1){1'b1}}};
		else o.ff = acc[DW-1:0];
		if (q > (64'd1 << (DW - 1))) o.dz = {1'b1, {(DW-1){1'b0}}};
		else o.dz = DW'(-q);
		return o;
	endfunction

	// one beat on the request channel; valid stays high into the next call unless a random idle gap drops it
	task automatic send_qsq(input logic [MASS_W-1:0] v, input bit typed, input ff_beat_t res);
		ff_beat_t e;
		req_valid <= 1'b1;
		momentum_sq <= v;
		do @(posedge clk); while (req_stall !== 1'b0);
		e = typed ? res : eval_form_factor(v);
		ff_expect_q.push_back(e);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// wait out every outstanding beat plus the pipeline tail
	task automatic drain();
		req_valid <= 1'b0;
		while (ff_expect_q.size() != 0) @(posedge clk);
		repeat (LAT + 16) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [MASS_W-1:0] fm, input logic [MASS_W-1:0] pm,
			input logic signed [DW-1:0] c0, input logic signed [DW-1:0] c1,
			input logic signed [DW-1:0] c2);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [31:0] val [5];
		idx = '{REG_FINAL_MASS, REG_PARENT_MASS, REG_COEF_ZERO, REG_COEF_ONE, REG_COEF_TWO};
		// upper data bit set at random on masses: the block must drop it
		val = '{{$urandom_range(0, 1) == 1, fm}, {$urandom_range(0, 1) == 1, pm}, c0, c1, c2};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
		m_final = fm; m_parent = pm; a0 = c0; a1 = c1; a2 = c2;
	endtask

	// in-range edge of qsq for the current masses, clipped to the port
	function automatic longint qsq_edge();
		logic [63:0] e;
		e = top_bound() >> FB;
		return (e > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : e;
	endfunction

	function automatic logic [MASS_W-1:0] clip_qsq(input longint v);
		if (v < 0) return '0;
		if (v > 64'h7FFF_FFFF) return '1;
		return v[MASS_W-1:0];
	endfunction

	task automatic random_items(input int n);
		longint e, v;
		ff_beat_t none;
		none = '0;
		for (int i = 0; i < n; i++) begin
			e = qsq_edge();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: v = $urandom_range(0, int'(e));
				5, 6:          v = e + longint'($urandom_range(0, 8)) - 4;
				default:       v = longint'(MASS_W'($urandom));
			endcase
			send_qsq(clip_qsq(v), 1'b0, none);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		ff_beat_t e;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			n_beats++;
			if (out_of_range === 1'b1) n_oor++;
			if (ff_expect_q.size() == 0) begin
				$error("unexpected result beat ff=%0d dz=%0d", form_factor, z_difference);
				n_fail++;
			end else begin
				e = ff_expect_q.pop_front();
				if (form_factor !== e.ff) begin
					$error("form_factor exp %0d got %0d", e.ff, form_factor);
					n_fail++;
				end
				if (z_difference !== e.dz) begin
					$error("z_difference exp %0d got %0d", e.dz, z_difference);
					n_fail++;
				end
				if (out_of_range !== e.oor) begin
					$error("out_of_range exp %0d got %0d", e.oor, out_of_range);
					n_fail++;
				end
			end
		end
	end

	// receiver back-pressure in bursts, none once quiet
	initial begin
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		ff_beat_t z;
		logic [MASS_W-1:0] q;
		m_final = '0; m_parent = '0; a0 = '0; a1 = '0; a2 = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// after reset every mass is zero: only qsq of zero is in range
		z = '0;
		rows.push_back('{0, 0, 1, z});
		z.oor = 1'b1;
		rows.push_back('{0, 1, 1, z});
		rows.push_back('{0, 64'h7FFF_FFFF, 1, z});
		rows.push_back('{0, 64'h2AAA_AAAA, 1, z});
		rows.push_back('{0, 64'h5555_5555, 1, z});
		foreach (rows[i]) send_qsq(clip_qsq(rows[i].qv), rows[i].typed, rows[i].res);
		drain();

		// B to light meson masses, modest coefficients
		write_cfg(31'd88_583_700, 31'd8_388_608, 32'sd5_033_165, -32'sd16_777_216,
			32'sd33_554_432);
		rows.delete();
		z = '0;
		rows.push_back('{1, 0, 0, z});
		rows.push_back('{1, 1, 0, z});
		rows.push_back('{1, -1, 0, z});
		rows.push_back('{0, 0, 0, z});
		rows.push_back('{0, 1, 0, z});
		rows.push_back('{0, 64'h7FFF_FFFF, 0, z});
		rows.push_back('{0, 64'h0100_0000, 0, z});
		rows.push_back('{0, 64'h0AAA_AAAA, 0, z});
		foreach (rows[i]) begin
			q = clip_qsq(rows[i].edge_rel ? qsq_edge() + rows[i].qv : rows[i].qv);
			send_qsq(q, rows[i].typed, rows[i].res);
		end
		random_items(90);
		drain();

		// extremes: largest masses, saturating coefficients
		write_cfg('1, '1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_qsq(MASS_W'($urandom), 1'b0, '0);
		random_items(80);
		drain();

		// one mass zero, most negative coefficients
		write_cfg('0, 31'd50_000_000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		random_items(80);
		drain();

		// equal masses, then random settings
		write_cfg(31'd30_000_000, 31'd30_000_000, 32'sd1 << 24, 32'sd3 << 24, -32'sd7 << 24);
		random_items(80);
		drain();

		for (int p = 0; p < 3; p++) begin
			write_cfg(MASS_W'($urandom_range(0, 32'h0800_0000)),
				MASS_W'($urandom_range(0, 32'h1000_0000)),
				$urandom, $urandom, $urandom);
			random_items(60);
			drain();
		end

		// last stretch with no idling on either side
		quiet = 1'b1;
		write_cfg(MASS_W'($urandom), MASS_W'($urandom),
			$urandom, $urandom, $urandom);
		random_items(60);
		drain();

		$display("covered %0d result beats, %0d of them out of range, over nine settings",
			n_beats, n_oor);
		$display("settings spanned zero and full-scale masses and saturating coefficients");
		if (n_fail == 0 && ff_expect_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ z_expansion_form_factor.f @@
rtl/core/zeff_pkg.sv
rtl/core/z_expansion_form_factor.sv
tb/tb_top.sv
